@@ rtl/ptcs_pkg.sv @@
package ptcs_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int MAX_RESULTS  = 32;
  localparam int NMW          = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_RADIUS = 2'd1;
  localparam logic [1:0] CMD_LOOK   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic        CFG_MAX_DISTANCE = 1'b0;
  localparam logic        CFG_MIN_COSINE   = 1'b1;

  localparam logic [22:0] MAX_DISTANCE_RST = 23'd10240;
  localparam logic [15:0] MIN_COSINE_RST   = 16'd29491;

  localparam logic [1:0] EMIT_ADD   = 2'd0;
  localparam logic [1:0] EMIT_PEND  = 2'd1;
  localparam logic [1:0] EMIT_FINAL = 2'd2;

  localparam logic MUL_DOT = 1'b0;
  localparam logic MUL_RHS = 1'b1;

  typedef struct packed {
    logic       load_item;
    logic       setup1;
    logic       setup2;
    logic       setup3;
    logic       diff;
    logic       sq;
    logic       sum;
    logic       next_idx;
    logic       take_match;
    logic       mul_start;
    logic       mul_sel;
    logic       cap_lhs;
    logic       take_best;
    logic       emit;
    logic [1:0] emit_kind;
  } ptcs_cmd_t;

  typedef struct packed {
    logic look;
    logic walk_end;
    logic rad_match;
    logic pend_valid;
    logic look_cand;
    logic in_cone;
    logic mul_done;
    logic out_free;
  } ptcs_stat_t;

endpackage

@@ rtl/ptcs_mul.sv @@
module ptcs_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] p
);

  logic [63:0]  a_r, b_r;
  logic [2:0]   k_r;
  logic         busy_r;
  logic [63:0]  prod_r;
  logic [1:0]   psh_r;
  logic         pv_r;
  logic [127:0] acc_r;
  logic         done_r;
  logic [31:0]  a_limb, b_limb;
  logic [127:0] addend;

  assign a_limb = k_r[0] ? a_r[63:32] : a_r[31:0];
  assign b_limb = k_r[1] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    case (psh_r)
      2'd0:    addend = {64'd0, prod_r};
      2'd1:    addend = {32'd0, prod_r, 32'd0};
      2'd2:    addend = {prod_r, 64'd0};
      default: addend = 128'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      k_r    <= 3'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      k_r    <= 3'd0;
    end else begin
      done_r <= busy_r && (k_r == 3'd4);
      if (busy_r) begin
        if (k_r != 3'd4) begin
          pv_r <= 1'b1;
          k_r  <= k_r + 3'd1;
        end else begin
          pv_r   <= 1'b0;
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= 128'd0;
    end else begin
      if (busy_r && k_r != 3'd4) begin
        prod_r <= a_limb * b_limb;
        psh_r  <= 2'(k_r[0]) + 2'(k_r[1]);
      end
      if (pv_r) begin
        acc_r <= acc_r + addend;
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

@@ rtl/ptcs_ctrl.sv @@
module ptcs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_stall,
  input  ptcs_pkg::ptcs_stat_t st,
  output ptcs_pkg::ptcs_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADD   = 4'd1;
  localparam logic [3:0] S_SET1  = 4'd2;
  localparam logic [3:0] S_SET2  = 4'd3;
  localparam logic [3:0] S_SET3  = 4'd4;
  localparam logic [3:0] S_FETCH = 4'd5;
  localparam logic [3:0] S_DIFF  = 4'd6;
  localparam logic [3:0] S_SQ    = 4'd7;
  localparam logic [3:0] S_SUM   = 4'd8;
  localparam logic [3:0] S_EVAL  = 4'd9;
  localparam logic [3:0] S_MULA  = 4'd10;
  localparam logic [3:0] S_MULAW = 4'd11;
  localparam logic [3:0] S_MULB  = 4'd12;
  localparam logic [3:0] S_MULBW = 4'd13;
  localparam logic [3:0] S_CMP   = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (in_cmd)
            ptcs_pkg::CMD_ADD:    state_nxt = S_ADD;
            ptcs_pkg::CMD_RADIUS: state_nxt = S_SET1;
            ptcs_pkg::CMD_LOOK:   state_nxt = S_SET1;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = ptcs_pkg::EMIT_ADD;
          state_nxt     = S_IDLE;
        end
      end
      S_SET1: begin
        cmd.setup1 = 1'b1;
        state_nxt  = S_SET2;
      end
      S_SET2: begin
        cmd.setup2 = 1'b1;
        state_nxt  = S_SET3;
      end
      S_SET3: begin
        cmd.setup3 = 1'b1;
        state_nxt  = S_FETCH;
      end
      S_FETCH: begin
        state_nxt = st.walk_end ? S_FIN : S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (st.look) begin
          if (st.look_cand) begin
            state_nxt = S_MULA;
          end else begin
            cmd.next_idx = 1'b1;
            state_nxt    = S_FETCH;
          end
        end else if (!st.rad_match) begin
          cmd.next_idx = 1'b1;
          state_nxt    = S_FETCH;
        end else if (!st.pend_valid || st.out_free) begin
          cmd.emit       = st.pend_valid;
          cmd.emit_kind  = ptcs_pkg::EMIT_PEND;
          cmd.take_match = 1'b1;
          cmd.next_idx   = 1'b1;
          state_nxt      = S_FETCH;
        end
      end
      S_MULA: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = ptcs_pkg::MUL_DOT;
        state_nxt     = S_MULAW;
      end
      S_MULAW: begin
        if (st.mul_done) begin
          cmd.cap_lhs = 1'b1;
          state_nxt   = S_MULB;
        end
      end
      S_MULB: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = ptcs_pkg::MUL_RHS;
        state_nxt     = S_MULBW;
      end
      S_MULBW: begin
        if (st.mul_done) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.take_best = st.in_cone;
        cmd.next_idx  = 1'b1;
        state_nxt     = S_FETCH;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = ptcs_pkg::EMIT_FINAL;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/ptcs_dp.sv @@
module ptcs_dp #(
  parameter int CAPACITY = ptcs_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ptcs_pkg::ptcs_cmd_t  cmd,
  output ptcs_pkg::ptcs_stat_t st,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [22:0]         cfg_data,
  input  logic [1:0]          in_cmd,
  input  logic signed [23:0]  in_pos_x,
  input  logic signed [23:0]  in_pos_y,
  input  logic signed [23:0]  in_pos_z,
  input  logic signed [15:0]  in_dir_x,
  input  logic signed [15:0]  in_dir_y,
  input  logic signed [15:0]  in_dir_z,
  input  logic [22:0]         in_radius,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [4:0]          out_hit_index,
  output logic                out_found,
  output logic                out_table_full,
  output logic                out_last
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NMW = ptcs_pkg::NMW;

  logic [22:0]        max_dist_r;
  logic signed [15:0] min_cos_r;

  logic               look_r;
  logic signed [23:0] px_r, py_r, pz_r;
  logic signed [15:0] fx_r, fy_r, fz_r;
  logic [22:0]        rad_r;

  logic [45:0]        r2_r;
  logic [30:0]        c2_r;
  logic [30:0]        fsx_r, fsy_r, fsz_r;
  logic [31:0]        f2_r;
  logic [62:0]        fc_r;

  logic [23:0]        mem_x [CAPACITY];
  logic [23:0]        mem_y [CAPACITY];
  logic [23:0]        mem_z [CAPACITY];
  logic [23:0]        rd_x_r, rd_y_r, rd_z_r;

  logic [IW-1:0]      count_r;
  logic [IW-1:0]      idx_r;
  logic               full;

  logic signed [24:0] dx_r, dy_r, dz_r;
  logic signed [49:0] sqx_r, sqy_r, sqz_r;
  logic signed [40:0] dotx_r, doty_r, dotz_r;
  logic [49:0]        d2_r;
  logic signed [41:0] dot_r;
  logic [41:0]        dot_mag;

  logic [49:0]        best2_r;
  logic [IW-1:0]      best_r;
  logic               have_r;
  logic               pend_valid_r;
  logic [IW-1:0]      pend_idx_r;
  logic [NMW-1:0]     nmatch_r;

  logic               mul_done;
  logic [127:0]       mul_p;
  logic [63:0]        mul_a, mul_b;
  logic [127:0]       lhs_r;

  logic               out_valid_r;
  logic [4:0]         out_idx_r;
  logic               out_found_r, out_full_r, out_last_r;
  logic               out_free;

  assign full     = (count_r >= IW'(CAPACITY));
  assign out_free = !out_valid_r || !out_stall;
  assign dot_mag  = dot_r[41] ? 42'(-dot_r) : 42'(dot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r <= ptcs_pkg::MAX_DISTANCE_RST;
      min_cos_r  <= ptcs_pkg::MIN_COSINE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ptcs_pkg::CFG_MAX_DISTANCE: max_dist_r <= cfg_data;
        ptcs_pkg::CFG_MIN_COSINE:   min_cos_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      look_r <= (in_cmd == ptcs_pkg::CMD_LOOK);
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      pz_r   <= in_pos_z;
      fx_r   <= in_dir_x;
      fy_r   <= in_dir_y;
      fz_r   <= in_dir_z;
      rad_r  <= in_radius;
    end
    if (cmd.setup1) begin
      r2_r  <= rad_r * rad_r;
      c2_r  <= 31'(min_cos_r * min_cos_r);
      fsx_r <= 31'(fx_r * fx_r);
      fsy_r <= 31'(fy_r * fy_r);
      fsz_r <= 31'(fz_r * fz_r);
    end
    if (cmd.setup2) begin
      f2_r <= 32'(fsx_r) + 32'(fsy_r) + 32'(fsz_r);
    end
    if (cmd.setup3) begin
      fc_r <= f2_r * c2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && cmd.emit_kind == ptcs_pkg::EMIT_ADD && !full) begin
      mem_x[count_r[AW-1:0]] <= px_r;
      mem_y[count_r[AW-1:0]] <= py_r;
      mem_z[count_r[AW-1:0]] <= pz_r;
    end
    rd_x_r <= mem_x[idx_r[AW-1:0]];
    rd_y_r <= mem_y[idx_r[AW-1:0]];
    rd_z_r <= mem_z[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx_r <= $signed({rd_x_r[23], rd_x_r}) - $signed({px_r[23], px_r});
      dy_r <= $signed({rd_y_r[23], rd_y_r}) - $signed({py_r[23], py_r});
      dz_r <= $signed({rd_z_r[23], rd_z_r}) - $signed({pz_r[23], pz_r});
    end
    if (cmd.sq) begin
      sqx_r  <= dx_r * dx_r;
      sqy_r  <= dy_r * dy_r;
      sqz_r  <= dz_r * dz_r;
      dotx_r <= dx_r * fx_r;
      doty_r <= dy_r * fy_r;
      dotz_r <= dz_r * fz_r;
    end
    if (cmd.sum) begin
      d2_r  <= 50'(sqx_r + sqy_r + sqz_r);
      dot_r <= 42'(dotx_r) + 42'(doty_r) + 42'(dotz_r);
    end
    if (cmd.cap_lhs) begin
      lhs_r <= mul_p << 30;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      idx_r        <= '0;
      have_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      nmatch_r     <= '0;
      best2_r      <= '0;
    end else begin
      if (cmd.emit && cmd.emit_kind == ptcs_pkg::EMIT_ADD && !full) begin
        count_r <= count_r + IW'(1);
      end
      if (cmd.setup1) begin
        best2_r <= 50'(max_dist_r * max_dist_r);
        have_r  <= 1'b0;
      end
      if (cmd.setup3) begin
        idx_r        <= '0;
        pend_valid_r <= 1'b0;
        nmatch_r     <= '0;
      end
      if (cmd.next_idx) begin
        idx_r <= idx_r + IW'(1);
      end
      if (cmd.take_match) begin
        pend_valid_r <= 1'b1;
        pend_idx_r   <= idx_r;
        nmatch_r     <= nmatch_r + NMW'(1);
      end
      if (cmd.take_best) begin
        best2_r <= d2_r;
        best_r  <= idx_r;
        have_r  <= 1'b1;
      end
    end
  end

  assign mul_a = (cmd.mul_sel == ptcs_pkg::MUL_DOT) ? 64'(dot_mag) : 64'(d2_r);
  assign mul_b = (cmd.mul_sel == ptcs_pkg::MUL_DOT) ? 64'(dot_mag) : 64'(fc_r);

  ptcs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_kind)
        ptcs_pkg::EMIT_ADD: begin
          out_idx_r   <= full ? 5'd0 : 5'(count_r);
          out_found_r <= !full;
          out_full_r  <= full;
          out_last_r  <= 1'b1;
        end
        ptcs_pkg::EMIT_PEND: begin
          out_idx_r   <= 5'(pend_idx_r);
          out_found_r <= 1'b1;
          out_full_r  <= 1'b0;
          out_last_r  <= 1'b0;
        end
        default: begin
          if (look_r) begin
            out_idx_r   <= have_r ? 5'(best_r) : 5'd0;
            out_found_r <= have_r;
          end else begin
            out_idx_r   <= pend_valid_r ? 5'(pend_idx_r) : 5'd0;
            out_found_r <= pend_valid_r;
          end
          out_full_r <= 1'b0;
          out_last_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit_index  = out_idx_r;
  assign out_found      = out_found_r;
  assign out_table_full = out_full_r;
  assign out_last       = out_last_r;

  always_comb begin
    st.look       = look_r;
    st.walk_end   = (idx_r >= count_r)
                    || (!look_r && nmatch_r >= NMW'(ptcs_pkg::MAX_RESULTS))
                    || (look_r && f2_r == 32'd0);
    st.rad_match  = (d2_r <= 50'(r2_r));
    st.pend_valid = pend_valid_r;
    st.look_cand  = (d2_r != 50'd0) && (d2_r < best2_r);
    st.in_cone    = min_cos_r[15] ? (!dot_r[41] || lhs_r <= mul_p)
                                  : (!dot_r[41] && lhs_r >= mul_p);
    st.mul_done   = mul_done;
    st.out_free   = out_free;
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free) else $error("emit into occupied output");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= IW'(CAPACITY)) else $error("point count above capacity");
  a_best_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> best2_r != 50'd0) else $error("selected point at zero distance");
  a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> nmatch_r != '0) else $error("pending match without count");
`endif

endmodule

@@ rtl/point_table_radius_and_cone_search.sv @@
// Add: result registered once the output is free; a full table stores nothing.
// Queries: setup steps S_SET1..S_SET3, then fetch, difference, square, sum and
// evaluate per stored point; a look-query point that passes the range test adds
// two 4-step passes of the 32x32 limb multiplier. One item at a time; the next
// item is taken once the last result is registered. rst_n (synchronous) empties
// the table and loads the register defaults; the point memory is not cleared.
module point_table_radius_and_cone_search #(
  parameter int CAPACITY = ptcs_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [22:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  input  logic [22:0]        in_radius,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_hit_index,
  output logic               out_found,
  output logic               out_table_full,
  output logic               out_last
);

  ptcs_pkg::ptcs_cmd_t  cmd;
  ptcs_pkg::ptcs_stat_t st;

  ptcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ptcs_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_cmd         (in_cmd),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_dir_x       (in_dir_x),
    .in_dir_y       (in_dir_y),
    .in_dir_z       (in_dir_z),
    .in_radius      (in_radius),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit_index  (out_hit_index),
    .out_found      (out_found),
    .out_table_full (out_table_full),
    .out_last       (out_last)
  );

endmodule

@@ dv/ptcs_scoreboard.sv @@
`timescale 1ns / 100ps

module ptcs_scoreboard (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [22:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  input  logic [22:0]        in_radius,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [4:0]         out_hit_index,
  input  logic               out_found,
  input  logic               out_table_full,
  input  logic               out_last,
  output int                 mism_count,
  output int                 pending_hits
);

  localparam int NPTS = 32;

  typedef struct packed {
    logic [4:0] idx;
    logic       found;
    logic       full;
    logic       last;
  } hit_t;

  logic signed [23:0] tab_x [NPTS];
  logic signed [23:0] tab_y [NPTS];
  logic signed [23:0] tab_z [NPTS];
  int                 n_pts;
  logic [22:0]        range_lim;
  logic signed [15:0] cone_cos;
  hit_t               hit_q [$];

  function automatic void queue_hit(logic [4:0] idx, logic found, logic full, logic last);
    hit_t h;
    h.idx   = idx;
    h.found = found;
    h.full  = full;
    h.last  = last;
    hit_q = {hit_q, h};
  endfunction

  function automatic longint sq_dist(int i, longint px, longint py, longint pz,
                                     output longint dx, output longint dy,
                                     output longint dz);
    dx = longint'(tab_x[i]) - px;
    dy = longint'(tab_y[i]) - py;
    dz = longint'(tab_z[i]) - pz;
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic void predict_hits(logic [1:0] cmd, logic signed [23:0] px,
                                       logic signed [23:0] py, logic signed [23:0] pz,
                                       logic signed [15:0] fx, logic signed [15:0] fy,
                                       logic signed [15:0] fz, logic [22:0] rad);
    longint      dx, dy, dz, d2, r2, f2, c2, best2, dot;
    logic [63:0] adot;
    logic [127:0] lhs, rhs;
    int          best, nm, last_m;
    logic        have, ins;
    best = 0;
    have = 1'b0;
    nm = 0;
    last_m = 0;
    case (cmd)
      ptcs_pkg::CMD_ADD: begin
        if (n_pts >= NPTS) begin
          queue_hit(5'd0, 1'b0, 1'b1, 1'b1);
        end else begin
          tab_x[n_pts] = px;
          tab_y[n_pts] = py;
          tab_z[n_pts] = pz;
          queue_hit(5'(n_pts), 1'b1, 1'b0, 1'b1);
          n_pts++;
        end
      end
      ptcs_pkg::CMD_RADIUS: begin
        r2 = longint'(rad) * longint'(rad);
        for (int i = 0; i < n_pts; i++) begin
          if (sq_dist(i, px, py, pz, dx, dy, dz) <= r2) begin
            nm++;
            last_m = i;
          end
        end
        if (nm == 0) begin
          queue_hit(5'd0, 1'b0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < n_pts; i++) begin
            if (sq_dist(i, px, py, pz, dx, dy, dz) <= r2) begin
              queue_hit(5'(i), 1'b1, 1'b0, i == last_m);
            end
          end
        end
      end
      ptcs_pkg::CMD_LOOK: begin
        f2 = longint'(fx) * fx + longint'(fy) * fy + longint'(fz) * fz;
        c2 = longint'(cone_cos) * longint'(cone_cos);
        best2 = longint'(range_lim) * longint'(range_lim);
        if (f2 != 0) begin
          for (int i = 0; i < n_pts; i++) begin
            d2 = sq_dist(i, px, py, pz, dx, dy, dz);
            if (d2 != 0 && d2 < best2) begin
              dot = dx * fx + dy * fy + dz * fz;
              adot = (dot < 0) ? 64'(-dot) : 64'(dot);
              lhs = (128'(adot) * 128'(adot)) << 30;
              rhs = 128'(d2) * 128'(f2) * 128'(c2);
              if (cone_cos >= 0) ins = (dot >= 0) && (lhs >= rhs);
              else ins = (dot >= 0) || (lhs <= rhs);
              if (ins) begin
                best2 = d2;
                best = i;
                have = 1'b1;
              end
            end
          end
        end
        queue_hit(have ? 5'(best) : 5'd0, have, 1'b0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    hit_t exp_h;
    if (!rst_n) begin
      n_pts = 0;
      range_lim = ptcs_pkg::MAX_DISTANCE_RST;
      cone_cos = ptcs_pkg::MIN_COSINE_RST;
      hit_q.delete();
      mism_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ptcs_pkg::CFG_MAX_DISTANCE) range_lim = cfg_data;
        else cone_cos = cfg_data[15:0];
      end
      if (in_valid && !in_stall)
        predict_hits(in_cmd, in_pos_x, in_pos_y, in_pos_z, in_dir_x, in_dir_y,
                     in_dir_z, in_radius);
      if (out_valid && !out_stall) begin
        if (hit_q.size() == 0) begin
          mism_count++;
          if (mism_count <= 10)
            $display("%0t: unexpected item idx=%0d found=%0b full=%0b last=%0b",
                     $realtime, out_hit_index, out_found, out_table_full, out_last);
        end else begin
          exp_h = hit_q.pop_front();
          if (exp_h.idx !== out_hit_index || exp_h.found !== out_found ||
              exp_h.full !== out_table_full || exp_h.last !== out_last) begin
            mism_count++;
            if (mism_count <= 10)
              $display("%0t: exp idx=%0d found=%0b full=%0b last=%0b, got %0d %0b %0b %0b",
                       $realtime, exp_h.idx, exp_h.found, exp_h.full, exp_h.last,
                       out_hit_index, out_found, out_table_full, out_last);
          end
        end
      end
    end
    pending_hits = hit_q.size();
  end

endmodule

@@ dv/tb_point_table_radius_and_cone_search.sv @@
`timescale 1ns / 100ps

module tb_point_table_radius_and_cone_search;

  localparam int WDOG_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_index = ptcs_pkg::CFG_MAX_DISTANCE;
  logic [22:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_cmd = ptcs_pkg::CMD_ADD;
  logic signed [23:0] in_pos_x = '0;
  logic signed [23:0] in_pos_y = '0;
  logic signed [23:0] in_pos_z = '0;
  logic signed [15:0] in_dir_x = '0;
  logic signed [15:0] in_dir_y = '0;
  logic signed [15:0] in_dir_z = '0;
  logic [22:0]        in_radius = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [4:0]         out_hit_index;
  logic               out_found;
  logic               out_table_full;
  logic               out_last;
  int                 mism_count;
  int                 pending_hits;

  int send_pct = 0;
  int recv_pct = 0;
  int n_taken = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;

  point_table_radius_and_cone_search u_top (.*);
  ptcs_scoreboard u_sb (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (in_valid && !in_stall) n_taken <= n_taken + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // long hold-off once, to back the block up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && n_taken >= 60) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  task automatic send_item(logic [1:0] c, logic signed [23:0] x, logic signed [23:0] y,
                           logic signed [23:0] z, logic signed [15:0] fx,
                           logic signed [15:0] fy, logic signed [15:0] fz,
                           logic [22:0] rad);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_dir_x <= fx;
    in_dir_y <= fy;
    in_dir_z <= fz;
    in_radius <= rad;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    while (pending_hits != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [22:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [23:0] rand_coord();
    if ($urandom_range(99) < 85) return 24'($urandom_range(4096)) - 24'sd2048;
    return 24'($urandom);
  endfunction

  task automatic rand_item();
    int          pick;
    logic [1:0]  c;
    logic signed [15:0] fx, fy, fz;
    logic [22:0] rad;
    pick = $urandom_range(99);
    if (pick < 30) c = ptcs_pkg::CMD_ADD;
    else if (pick < 62) c = ptcs_pkg::CMD_RADIUS;
    else if (pick < 95) c = ptcs_pkg::CMD_LOOK;
    else c = ptcs_pkg::CMD_UNUSED;
    if ($urandom_range(99) < 5) begin
      fx = '0;
      fy = '0;
      fz = '0;
    end else begin
      fx = 16'($urandom);
      fy = 16'($urandom);
      fz = 16'($urandom);
    end
    rad = ($urandom_range(99) < 85) ? 23'($urandom_range(3000)) : 23'($urandom);
    send_item(c, rand_coord(), rand_coord(), rand_coord(), fx, fy, fz, rad);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(ptcs_pkg::CMD_RADIUS, 0, 0, 0, 0, 0, 0, 23'h7fffff);
    send_item(ptcs_pkg::CMD_LOOK, 0, 0, 0, 16'sh7fff, 0, 0, 0);
    send_item(ptcs_pkg::CMD_ADD, 0, 0, 0, 0, 0, 0, 0);
    send_item(ptcs_pkg::CMD_ADD, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 0, 0, 0, 0);
    send_item(ptcs_pkg::CMD_ADD, -24'sh800000, -24'sh800000, -24'sh800000, 0, 0, 0, 0);
    send_item(ptcs_pkg::CMD_ADD, 512, 0, 0, 0, 0, 0, 0);
    send_item(ptcs_pkg::CMD_ADD, 512, 0, 0, 0, 0, 0, 0);
    send_item(ptcs_pkg::CMD_ADD, 0, 256, 0, 0, 0, 0, 0);
    send_item(ptcs_pkg::CMD_ADD, -600, 10, 0, 0, 0, 0, 0);
    send_item(ptcs_pkg::CMD_LOOK, 0, 0, 0, 16'sh7fff, 0, 0, 0);
    send_item(ptcs_pkg::CMD_LOOK, 512, 0, 0, -16'sh8000, 0, 0, 0);
    send_item(ptcs_pkg::CMD_LOOK, 0, 0, 0, 0, 0, 0, 0);
    send_item(ptcs_pkg::CMD_LOOK, 0, 0, 0, -16'sh8000, -16'sh8000, -16'sh8000, 0);
    send_item(ptcs_pkg::CMD_LOOK, 0, -100, 0, 0, 16'sh7fff, 0, 0);
    send_item(ptcs_pkg::CMD_RADIUS, 512, 0, 0, 0, 0, 0, 0);
    send_item(ptcs_pkg::CMD_RADIUS, 0, 0, 0, 0, 0, 0, 23'h7fffff);
    send_item(ptcs_pkg::CMD_RADIUS, 0, 0, 0, 0, 0, 0, 300);
    send_item(ptcs_pkg::CMD_UNUSED, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 23'h7fffff);
    send_item(ptcs_pkg::CMD_RADIUS, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 0, 0, 0,
              23'h7fffff);

    for (int ph = 0; ph < 4; ph++) begin
      drain_and_idle();
      case (ph)
        0: begin
          write_reg(ptcs_pkg::CFG_MAX_DISTANCE, 23'h7fffff);
          write_reg(ptcs_pkg::CFG_MIN_COSINE, {7'd0, 16'h8000});
          send_pct = 15;
          recv_pct = 58;
        end
        1: begin
          write_reg(ptcs_pkg::CFG_MAX_DISTANCE, 23'd3000);
          write_reg(ptcs_pkg::CFG_MIN_COSINE, {7'd0, 16'h7fff});
          send_pct = 58;
          recv_pct = 15;
        end
        2: begin
          write_reg(ptcs_pkg::CFG_MAX_DISTANCE, 23'($urandom_range(20000, 2000)));
          write_reg(ptcs_pkg::CFG_MIN_COSINE, {7'd0, 16'($urandom_range(40000))});
          send_pct = 0;
          recv_pct = 0;
        end
        default: begin
          write_reg(ptcs_pkg::CFG_MAX_DISTANCE, 23'd0);
          write_reg(ptcs_pkg::CFG_MIN_COSINE, {7'd0, 16'd0});
        end
      endcase
      for (int k = 0; k < ((ph == 3) ? 30 : 150); k++) rand_item();
    end

    in_valid <= 1'b0;
    while (pending_hits != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (mism_count == 0 && pending_hits == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
